// ===== rtl/hypergraph_node_edge_centrality_top_assert.svh =====
// Assertion macros used by the checker module.
`ifndef HYPERGRAPH_NODE_EDGE_CENTRALITY_TOP_ASSERT_SVH
`define HYPERGRAPH_NODE_EDGE_CENTRALITY_TOP_ASSERT_SVH

// same-cycle implication
`define HNEC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hnec check failed");

// next-cycle implication
`define HNEC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hnec check failed");

`endif

// ===== rtl/hnec_pkg.sv =====
package hnec_pkg;

   localparam int IDX_W     = 5;
   localparam int SCORE_W   = 32;
   localparam int WEIGHT_W  = 16;
   localparam int ROUND_W   = 16;
   localparam int COUNT_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;
   localparam int ACC_W     = 54;
   localparam int RAD_W     = 80;
   localparam int ROOT_W    = 40;
   localparam int RAW_W     = 35;
   localparam int SUM_W     = 41;
   localparam int DIFF_W    = 39;
   localparam int WIDE_W    = 70;
   localparam int PROD_W    = 65;
   localparam int INC_DEPTH = 1024;
   localparam int SCORE_DEPTH = 128;
   localparam int RAW_DEPTH = 64;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 2'd3;

   // 2^31 / count, indexed by count - 1
   localparam logic [SCORE_W-1:0] INIT_SHARE [32] = '{
      32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
      32'd429496729,  32'd357913941,  32'd306783378, 32'd268435456,
      32'd238609294,  32'd214748364,  32'd195225786, 32'd178956970,
      32'd165191049,  32'd153391689,  32'd143165576, 32'd134217728,
      32'd126322567,  32'd119304647,  32'd113025455, 32'd107374182,
      32'd102261126,  32'd97612893,   32'd93368854,  32'd89478485,
      32'd85899345,   32'd82595524,   32'd79536431,  32'd76695844,
      32'd74051160,   32'd71582788,   32'd69273666,  32'd67108864
   };

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_ACC_RD,
      ST_ACC_SQ,
      ST_ACC_MW,
      ST_ACC_ADD,
      ST_RT1_GO,
      ST_RT1,
      ST_OM0,
      ST_OM1,
      ST_OM2,
      ST_RT2_GO,
      ST_RT2,
      ST_RAW_WR,
      ST_NM_RD,
      ST_NM_GO,
      ST_NM_DIV,
      ST_NM_WR,
      ST_RND_END,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic                cmd;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic               is_edge;
      logic [IDX_W-1:0]   index;
      logic [SCORE_W-1:0] score;
      logic               converged;
      logic [ROUND_W-1:0] rounds;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/hnec_sqrt.sv =====
module hnec_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hnec_pkg::RAD_W-1:0] radicand,
   output logic                       done,
   output logic [hnec_pkg::ROOT_W-1:0] root
);
   import hnec_pkg::*;

   localparam int REM_W  = ROOT_W + 3;
   localparam int STEP_W = 6;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/hnec_div.sv =====
module hnec_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hnec_pkg::RAW_W-1:0]   dividend,
   input  logic [hnec_pkg::SUM_W-1:0]   divisor,
   output logic                         done,
   output logic [hnec_pkg::SCORE_W-1:0] quotient
);
   import hnec_pkg::*;

   localparam int REM_W  = SUM_W + 1;
   localparam int STEP_W = 5;

   logic [REM_W-1:0]   rem_ff;
   logic [SUM_W-1:0]   div_ff;
   logic [SCORE_W-1:0] quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic               fits;
   logic [REM_W-1:0]   rem_sub;

   assign fits    = rem_ff >= {1'b0, div_ff};
   assign rem_sub = fits ? rem_ff - {1'b0, div_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(SCORE_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= REM_W'(dividend);
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= {rem_sub[REM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[SCORE_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/hypergraph_node_edge_centrality_top.sv =====
// Hypergraph node and hyperedge centrality by nonlinear power iteration.
// Request beats (req_valid/req_ready, req_payload): cmd 0 writes one
// incidence weight at (row, col), one beat per cycle while idle; cmd 1
// starts a run. During a run req_ready stays low.
// Response beats (rsp_valid/rsp_ready, rsp_payload): node scores, then
// hyperedge scores, last set on the final beat; each beat runs through
// states OUT_RD, OUT_LD and OUT_WAIT, and the block waits while the
// receiver holds ready low. The datapath has one shared 33x32
// multiplier, a square-root unit resolving two radicand bits per cycle
// (two roots per score) and a bit-serial divider (one division per
// normalised score). Configuration (csr_we/csr_index/csr_wdata) must be
// written only while idle; the block itself does not enforce this.
// Reset (synchronous, active high) returns to idle with counts 32,
// iteration limit 100 and tolerance 2147; the incidence memory keeps
// whatever it holds and must be written before use.
module hypergraph_node_edge_centrality_top #(
   parameter int MAX_NODES = 32,
   parameter int MAX_EDGES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hnec_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hnec_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [hnec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hnec_pkg::CSR_W-1:0]       csr_wdata
);
   import hnec_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] node_count_ff, edge_count_ff;
   logic [ROUND_W-1:0] limit_ff;
   logic [SCORE_W-1:0] tol_ff;

   logic               bank_ff, bank_in;
   logic               phase_ff, phase_in;
   logic [IDX_W-1:0]   oc_ff, oc_in;
   logic [IDX_W-1:0]   ic_ff, ic_in;
   logic [ROUND_W-1:0] rounds_ff, rounds_in;
   logic               conv_ff, conv_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DIFF_W-1:0]  diff_ff, diff_in;
   logic [WIDE_W-1:0]  wide_ff, wide_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [WEIGHT_W-1:0] inc_mem [INC_DEPTH];
   logic [SCORE_W-1:0]  score_mem [SCORE_DEPTH];
   logic [RAW_W-1:0]    raw_mem [RAW_DEPTH];
   logic [WEIGHT_W-1:0] inc_rd_ff;
   logic [SCORE_W-1:0]  score_rd_ff;
   logic [RAW_W-1:0]    raw_rd_ff;

   logic [2*IDX_W-1:0]  inc_raddr;
   logic [IDX_W+1:0]    score_raddr, score_waddr;
   logic [IDX_W:0]      raw_addr;
   logic                score_we, raw_we, inc_we;
   logic [SCORE_W-1:0]  score_wdata;

   logic [COUNT_W-1:0]  n_cnt, m_cnt;
   logic [IDX_W-1:0]    n_last, m_last, own_last, inner_last;
   logic                req_accept;

   logic [PROD_W-33:0]  mul_a;
   logic [SCORE_W-1:0]  mul_b;

   logic                sqrt_start, sqrt_done;
   logic [RAD_W-1:0]    sqrt_rad;
   logic [ROOT_W-1:0]   sqrt_root;
   logic                div_start, div_done;
   logic [SCORE_W-1:0]  div_q;
   logic [SCORE_W-1:0]  norm_q;
   logic [SCORE_W-1:0]  abs_diff;

   always_comb begin
      if (node_count_ff == '0) begin
         n_cnt = COUNT_W'(1);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         n_cnt = COUNT_W'(MAX_NODES);
      end else begin
         n_cnt = node_count_ff;
      end
      if (edge_count_ff == '0) begin
         m_cnt = COUNT_W'(1);
      end else if (edge_count_ff > COUNT_W'(MAX_EDGES)) begin
         m_cnt = COUNT_W'(MAX_EDGES);
      end else begin
         m_cnt = edge_count_ff;
      end
   end

   assign n_last     = IDX_W'(n_cnt - 1'b1);
   assign m_last     = IDX_W'(m_cnt - 1'b1);
   assign own_last   = phase_ff ? m_last : n_last;
   assign inner_last = phase_ff ? n_last : m_last;

   assign req_ready  = state_ff == ST_IDLE;
   assign req_accept = req_valid && req_ready;
   assign inc_we     = req_accept && req_payload.cmd == CMD_WRITE
                       && {1'b0, req_payload.row} < COUNT_W'(MAX_NODES)
                       && {1'b0, req_payload.col} < COUNT_W'(MAX_EDGES);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(32);
         edge_count_ff <= COUNT_W'(32);
         limit_ff      <= ROUND_W'(100);
         tol_ff        <= SCORE_W'(2147);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_EDGE_COUNT: edge_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ITER_LIMIT: limit_ff      <= csr_wdata[ROUND_W-1:0];
            CSR_TOLERANCE:  tol_ff        <= csr_wdata[SCORE_W-1:0];
            default: ;
         endcase
      end
   end

   // memory addressing
   always_comb begin
      inc_raddr = phase_ff ? {ic_ff, oc_ff} : {oc_ff, ic_ff};
      raw_addr  = {phase_ff, oc_ff};
      if (state_ff == ST_ACC_RD || state_ff == ST_ACC_SQ
          || state_ff == ST_ACC_MW || state_ff == ST_ACC_ADD) begin
         score_raddr = {bank_ff, ~phase_ff, ic_ff};
      end else begin
         score_raddr = {bank_ff, phase_ff, oc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (inc_we) begin
         inc_mem[{req_payload.row, req_payload.col}] <= req_payload.weight;
      end
      inc_rd_ff <= inc_mem[inc_raddr];
   end

   always_ff @(posedge clock) begin
      if (score_we) begin
         score_mem[score_waddr] <= score_wdata;
      end
      score_rd_ff <= score_mem[score_raddr];
   end

   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_mem[raw_addr] <= sqrt_root[RAW_W-1:0];
      end
      raw_rd_ff <= raw_mem[raw_addr];
   end

   hnec_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   hnec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (raw_rd_ff),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sqrt_start = state_ff == ST_RT1_GO || state_ff == ST_RT2_GO;
   assign sqrt_rad   = state_ff == ST_RT1_GO ? RAD_W'({acc_ff, 22'd0}) : RAD_W'(wide_ff);
   assign div_start  = state_ff == ST_NM_GO;
   assign norm_q     = sum_ff == '0 ? raw_rd_ff[SCORE_W-1:0] : div_q;
   assign abs_diff   = norm_q >= score_rd_ff ? norm_q - score_rd_ff : score_rd_ff - norm_q;
   assign prod_in    = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_accept && req_payload.cmd == CMD_START) begin
               state_in = ST_INIT;
            end
         ST_INIT:
            if (oc_ff == own_last && phase_ff) begin
               state_in = limit_ff == '0 ? ST_OUT_RD : ST_ACC_RD;
            end
         ST_ACC_RD:  state_in = ST_ACC_SQ;
         ST_ACC_SQ:  state_in = ST_ACC_MW;
         ST_ACC_MW:  state_in = ST_ACC_ADD;
         ST_ACC_ADD: state_in = ic_ff == inner_last ? ST_RT1_GO : ST_ACC_RD;
         ST_RT1_GO:  state_in = ST_RT1;
         ST_RT1:     if (sqrt_done) state_in = ST_OM0;
         ST_OM0:     state_in = ST_OM1;
         ST_OM1:     state_in = ST_OM2;
         ST_OM2:     state_in = ST_RT2_GO;
         ST_RT2_GO:  state_in = ST_RT2;
         ST_RT2:     if (sqrt_done) state_in = ST_RAW_WR;
         ST_RAW_WR:  state_in = oc_ff == own_last ? ST_NM_RD : ST_ACC_RD;
         ST_NM_RD:   state_in = ST_NM_GO;
         ST_NM_GO:   state_in = ST_NM_DIV;
         ST_NM_DIV:  if (div_done) state_in = ST_NM_WR;
         ST_NM_WR:
            if (oc_ff == own_last) begin
               state_in = phase_ff ? ST_RND_END : ST_ACC_RD;
            end else begin
               state_in = ST_NM_RD;
            end
         ST_RND_END:
            if (diff_ff < DIFF_W'(tol_ff) || rounds_ff + 1'b1 == limit_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_ACC_RD;
            end
         ST_OUT_RD:  state_in = ST_OUT_LD;
         ST_OUT_LD:  state_in = ST_OUT_WAIT;
         ST_OUT_WAIT:
            if (rsp_ready) begin
               state_in = rsp_data_ff.last ? ST_IDLE : ST_OUT_RD;
            end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      bank_in      = bank_ff;
      phase_in     = phase_ff;
      oc_in        = oc_ff;
      ic_in        = ic_ff;
      rounds_in    = rounds_ff;
      conv_in      = conv_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      wide_in      = wide_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = {1'b0, score_rd_ff};
      mul_b        = score_rd_ff;
      score_we     = 1'b0;
      score_waddr  = {~bank_ff, phase_ff, oc_ff};
      score_wdata  = norm_q;
      raw_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            phase_in = 1'b0;
            oc_in    = '0;
         end
         ST_INIT: begin
            score_we    = 1'b1;
            score_waddr = {bank_ff, phase_ff, oc_ff};
            score_wdata = INIT_SHARE[own_last];
            if (oc_ff == own_last) begin
               oc_in = '0;
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  phase_in  = 1'b0;
                  ic_in     = '0;
                  acc_in    = '0;
                  sum_in    = '0;
                  diff_in   = '0;
                  rounds_in = '0;
                  conv_in   = 1'b0;
               end
            end else begin
               oc_in = oc_ff + 1'b1;
            end
         end
         ST_ACC_MW: begin
            mul_a = prod_ff[62:30];
            mul_b = SCORE_W'(inc_rd_ff);
         end
         ST_ACC_ADD: begin
            acc_in = acc_ff + ACC_W'(prod_ff[48:0]);
            ic_in  = ic_ff == inner_last ? '0 : ic_ff + 1'b1;
         end
         ST_OM0: begin
            mul_b = sqrt_root[SCORE_W-1:0];
         end
         ST_OM1: begin
            wide_in = WIDE_W'(prod_ff[63:0]);
            mul_b   = SCORE_W'(sqrt_root[37:32]);
         end
         ST_OM2: begin
            wide_in = wide_ff + {prod_ff[37:0], 32'd0};
         end
         ST_RAW_WR: begin
            raw_we = 1'b1;
            sum_in = sum_ff + SUM_W'(sqrt_root[RAW_W-1:0]);
            acc_in = '0;
            oc_in  = oc_ff == own_last ? '0 : oc_ff + 1'b1;
         end
         ST_NM_WR: begin
            score_we = 1'b1;
            diff_in  = diff_ff + DIFF_W'(abs_diff);
            if (oc_ff == own_last) begin
               oc_in = '0;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  sum_in   = '0;
                  acc_in   = '0;
                  ic_in    = '0;
               end
            end else begin
               oc_in = oc_ff + 1'b1;
            end
         end
         ST_RND_END: begin
            rounds_in = rounds_ff + 1'b1;
            bank_in   = ~bank_ff;
            phase_in  = 1'b0;
            oc_in     = '0;
            ic_in     = '0;
            sum_in    = '0;
            acc_in    = '0;
            diff_in   = '0;
            if (diff_ff < DIFF_W'(tol_ff)) begin
               conv_in = 1'b1;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.is_edge   = phase_ff;
            rsp_data_in.index     = oc_ff;
            rsp_data_in.score     = score_rd_ff;
            rsp_data_in.converged = conv_ff;
            rsp_data_in.rounds    = rounds_ff;
            rsp_data_in.last      = phase_ff && oc_ff == m_last;
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (oc_ff == own_last) begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     oc_in    = '0;
                  end
               end else begin
                  oc_in = oc_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         oc_ff        <= '0;
         ic_ff        <= '0;
         rounds_ff    <= '0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         phase_ff     <= phase_in;
         oc_ff        <= oc_in;
         ic_ff        <= ic_in;
         rounds_ff    <= rounds_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      wide_ff     <= wide_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== rtl/hnec_checker.sv =====
`include "hypergraph_node_edge_centrality_top_assert.svh"

module hnec_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input hnec_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hnec_pkg::rsp_type rsp_payload
);
   import hnec_pkg::*;

   `HNEC_ASSERT_IMPL(a_busy_while_rsp, rsp_valid, !req_ready)
   `HNEC_ASSERT_NEXT(a_start_busy, req_valid && req_ready && req_payload.cmd == CMD_START, !req_ready)
   `HNEC_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_ready && rsp_payload.last, req_ready && !rsp_valid)
   `HNEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind hypergraph_node_edge_centrality_top hnec_checker u_hnec_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
